>>> rtl/tun_pkg.sv
// tun_pkg: shared widths, types and the per-triangle job word
// used by the front classifier, the queue and the rounding/divide back end
package tun_pkg;

  localparam int CoordW   = 16;
  localparam int FracW    = 14;
  localparam int NormW    = FracW + 2;
  localparam int EdgeW    = CoordW + 1;
  localparam int CrossW   = 2 * EdgeW + 1;
  localparam int MagW     = CrossW - 1;
  localparam int SumW     = 2 * CrossW + 2;
  localparam int QW       = FracW + 1;
  localparam int FifoDepth = 4;
  localparam int FifoAw   = $clog2(FifoDepth);

  typedef struct packed {
    logic                     degenerate;
    logic [2:0]               neg;
    logic [2:0][SumW-1:0]     csq;
    logic [SumW-1:0]          sum;
  } job_t;

endpackage

>>> rtl/tun_front.sv
// tun_front: edge vectors, cross product, squared length
// depends on tun_pkg; two register stages, one triangle per cycle
module tun_front
  import tun_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [CoordW-1:0] p1x_i, p1y_i, p1z_i,
  input  logic signed [CoordW-1:0] p2x_i, p2y_i, p2z_i,
  input  logic signed [CoordW-1:0] p3x_i, p3y_i, p3z_i,
  output logic                     out_valid_o,
  output job_t                     out_job_o
);
  logic signed [EdgeW-1:0] ax, ay, az, bx, by, bz;
  logic signed [CrossW-1:0] c_d [3];
  logic signed [CrossW-1:0] c_q [3];
  logic v1_q, v2_q;
  job_t job_d, job_q;
  logic [MagW-1:0] m [3];
  logic [2*MagW-1:0] sq [3];

  assign ax = EdgeW'(p1x_i) - EdgeW'(p2x_i);
  assign ay = EdgeW'(p1y_i) - EdgeW'(p2y_i);
  assign az = EdgeW'(p1z_i) - EdgeW'(p2z_i);
  assign bx = EdgeW'(p3x_i) - EdgeW'(p2x_i);
  assign by = EdgeW'(p3y_i) - EdgeW'(p2y_i);
  assign bz = EdgeW'(p3z_i) - EdgeW'(p2z_i);

  assign c_d[0] = CrossW'(ay * bz) - CrossW'(by * az);
  assign c_d[1] = CrossW'(bx * az) - CrossW'(ax * bz);
  assign c_d[2] = CrossW'(ax * by) - CrossW'(bx * ay);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i] = c_q[i][CrossW-1] ? MagW'(-c_q[i]) : MagW'(c_q[i]);
      sq[i] = m[i] * m[i];
      job_d.neg[i] = c_q[i][CrossW-1];
      job_d.csq[i] = SumW'(sq[i]);
    end
    job_d.sum = job_d.csq[0] + job_d.csq[1] + job_d.csq[2];
    job_d.degenerate = (m[0] == '0) && (m[1] == '0) && (m[2] == '0);
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_job_o   = job_q;
endmodule

>>> rtl/tun_fifo.sv
// tun_fifo: short job queue between front and back end
// depends on tun_pkg
module tun_fifo
  import tun_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t din_i,
  input  logic pop_i,
  output job_t dout_o,
  output logic empty_o,
  output logic [FifoAw:0] count_o
);
  job_t mem_q [FifoDepth];
  logic [FifoAw:0] wr_q, rd_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q[FifoAw-1:0]] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
    end
  end

  assign dout_o  = mem_q[rd_q[FifoAw-1:0]];
  assign count_o = wr_q - rd_q;
  assign empty_o = (wr_q == rd_q);
endmodule

>>> rtl/tun_back.sv
// tun_back: rounded scaled magnitude by shift-and-add search, all three lanes
// depends on tun_pkg; one bit of q per cycle, one job at a time
module tun_back
  import tun_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  job_t                    job_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  output logic signed [NormW-1:0] nx_o, ny_o, nz_o,
  output logic                    degen_o
);
  localparam int CmpW = SumW + 2 * QW + 2;
  localparam int BitW = $clog2(QW + 1);
  logic busy_q;
  logic [BitW-1:0] bit_q;
  job_t job_q;
  logic [QW-1:0] q_q [3];
  // a_q holds q*q*sum and b_q holds q*sum for the bits decided so far
  logic [CmpW-1:0] a_q [3];
  logic [CmpW-1:0] b_q [3];
  logic [QW-1:0] cand [3];
  logic [CmpW-1:0] cand_a [3];
  logic [CmpW-1:0] cand_b [3];
  logic [CmpW-1:0] sum_w, sk, s2k;
  logic [CmpW-1:0] lhs [3];
  logic [CmpW-1:0] rhs [3];
  logic ok [3];
  logic done;

  assign sum_w = CmpW'(job_q.sum);
  assign sk    = sum_w << bit_q;
  assign s2k   = sum_w << {bit_q, 1'b0};

  // (2*cand-1)^2 * sum = 4*(cand^2 - cand)*sum + sum, built from shifts and adds
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i]   = q_q[i] | (QW'(1) << bit_q);
      cand_a[i] = a_q[i] + (b_q[i] << (bit_q + 1'b1)) + s2k;
      cand_b[i] = b_q[i] + sk;
      lhs[i]    = ((cand_a[i] - cand_b[i]) << 2) + sum_w;
      rhs[i]    = CmpW'(job_q.csq[i]) << (2 * FracW + 2);
      ok[i]     = lhs[i] <= rhs[i];
    end
  end

  assign done  = busy_q && (bit_q == '0);
  assign pop_o = !busy_q && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      for (int i = 0; i < 3; i++) begin
        q_q[i] <= '0;
        a_q[i] <= '0;
        b_q[i] <= '0;
      end
    end else if (busy_q && !job_q.degenerate) begin
      for (int i = 0; i < 3; i++) begin
        if (ok[i]) begin
          q_q[i] <= cand[i];
          a_q[i] <= cand_a[i];
          b_q[i] <= cand_b[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= done;
      if (pop_o) begin
        busy_q <= 1'b1;
        bit_q  <= BitW'(QW - 1);
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        bit_q <= bit_q - 1'b1;
      end
    end
  end

  logic signed [NormW-1:0] r [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = job_q.neg[i] ? -NormW'(q_q[i]) : NormW'(q_q[i]);
    end
  end
  assign nx_o = job_q.degenerate ? '0 : r[0];
  assign ny_o = job_q.degenerate ? '0 : r[1];
  assign nz_o = job_q.degenerate ? '0 : r[2];
  assign degen_o = job_q.degenerate;
endmodule

>>> rtl/triangle_unit_normal_core.sv
// triangle_unit_normal_core: top level, front + queue + back end
// depends on tun_pkg, tun_front, tun_fifo, tun_back
// channel   | handshake         | payload
// command   | start_i / busy_o  | first_*, second_*, third_* (Q8.8)
// result    | done_o strobe     | normal_* (Q1.14), degenerate_o
// the back end loads a triangle, then decides one bit of q per cycle over
// 15 bits, and takes the next only after it is done; the front takes one per
// cycle while busy_o is low, and busy_o rises once three triangles are
// in the front pipeline or the queue.
// reset clears the pipeline and queue; results cannot be stalled.
module triangle_unit_normal_core
  import tun_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic signed [CoordW-1:0] first_x_i, first_y_i, first_z_i,
  input  logic signed [CoordW-1:0] second_x_i, second_y_i, second_z_i,
  input  logic signed [CoordW-1:0] third_x_i, third_y_i, third_z_i,
  output logic done_o,
  output logic signed [NormW-1:0] normal_x_o, normal_y_o, normal_z_o,
  output logic degenerate_o
);
  logic acc, fv, pop, empty, v1_q, v2_q;
  job_t fj, qj;
  logic [FifoAw:0] cnt;
  logic [FifoAw+1:0] load;

  assign acc = start_i && !busy_o;
  // count queued plus in front pipeline
  assign load = (FifoAw+2)'(cnt) + (FifoAw+2)'(v1_q) + (FifoAw+2)'(v2_q);
  assign busy_o = load >= (FifoAw+2)'(FifoDepth - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
    end
  end

  tun_front u_front (
    .clk_i, .rst_ni, .in_valid_i(acc),
    .p1x_i(first_x_i), .p1y_i(first_y_i), .p1z_i(first_z_i),
    .p2x_i(second_x_i), .p2y_i(second_y_i), .p2z_i(second_z_i),
    .p3x_i(third_x_i), .p3y_i(third_y_i), .p3z_i(third_z_i),
    .out_valid_o(fv), .out_job_o(fj)
  );

  tun_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(fv), .din_i(fj), .pop_i(pop),
    .dout_o(qj), .empty_o(empty), .count_o(cnt)
  );

  tun_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(qj), .pop_o(pop),
    .res_valid_o(done_o), .nx_o(normal_x_o), .ny_o(normal_y_o),
    .nz_o(normal_z_o), .degen_o(degenerate_o)
  );
endmodule

>>> rtl/tun_checker.sv
// tun_checker: port-level checks on triangle_unit_normal_core
// depends on tun_pkg; bound to the top level
module tun_checker
  import tun_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic done_o,
  input logic signed [NormW-1:0] normal_x_o,
  input logic signed [NormW-1:0] normal_y_o,
  input logic signed [NormW-1:0] normal_z_o,
  input logic degenerate_o
);
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0)
    else $error("degenerate result not zero");
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back to back results");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> normal_x_o <= 16384 && normal_x_o >= -16384)
    else $error("normal out of range");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !done_o && !busy_o) else $error("not idle right after reset");
endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (.*);

>>> dv/triangle_unit_normal_core_tb.sv
// triangle_unit_normal_core_tb: self-checking bench for the triangle unit normal core
// directed table then random triangles, each result checked against an exact normal predictor
// depends on tun_pkg and triangle_unit_normal_core
module triangle_unit_normal_core_tb;
  import tun_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NormW-1:0] norm_t;

  // vertex order: first xyz, second xyz, third xyz
  typedef struct {
    coord_t v[9];
  } tri_t;

  typedef struct {
    norm_t nx, ny, nz;
    logic  degen;
  } normal_t;

  typedef struct {
    tri_t    t;
    logic    known;
    normal_t n;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, degenerate_o;
  coord_t first_x_i = '0, first_y_i = '0, first_z_i = '0;
  coord_t second_x_i = '0, second_y_i = '0, second_z_i = '0;
  coord_t third_x_i = '0, third_y_i = '0, third_z_i = '0;
  norm_t normal_x_o, normal_y_o, normal_z_o;

  normal_t pending_normals[$];
  int      n_errors = 0;
  logic    quiet = 1'b0;

  triangle_unit_normal_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i, .first_y_i, .first_z_i,
    .second_x_i, .second_y_i, .second_z_i,
    .third_x_i, .third_y_i, .third_z_i,
    .done_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("error at %0t: %s", $realtime, msg);
  endtask

  // round(|c| * 2^FracW / len), ties away from zero, by binary search on squares
  function automatic logic [FracW:0] scale_component(logic [127:0] cmag, logic [127:0] sumsq);
    logic [127:0] rhs, lhs, d;
    int lo, hi, mid;
    rhs = (cmag * cmag) << (2 * FracW + 2);
    lo = 0;
    hi = 1 << FracW;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 128'(2 * mid - 1);
      lhs = d * d * sumsq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (FracW + 1)'(lo);
  endfunction

  function automatic normal_t face_normal(tri_t t);
    longint ea[3], eb[3], c[3];
    logic [127:0] m[3];
    logic [127:0] sumsq;
    logic [FracW:0] q;
    norm_t r[3];
    normal_t n;
    for (int i = 0; i < 3; i++) begin
      ea[i] = longint'(t.v[i]) - longint'(t.v[3+i]);
      eb[i] = longint'(t.v[6+i]) - longint'(t.v[3+i]);
    end
    c[0] = ea[1] * eb[2] - eb[1] * ea[2];
    c[1] = eb[0] * ea[2] - ea[0] * eb[2];
    c[2] = ea[0] * eb[1] - eb[0] * ea[1];
    n = '{default: '0};
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      n.degen = 1'b1;
      return n;
    end
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 128'(c[i] < 0 ? -c[i] : c[i]);
      sumsq += m[i] * m[i];
    end
    for (int i = 0; i < 3; i++) begin
      q = scale_component(m[i], sumsq);
      r[i] = c[i] < 0 ? -norm_t'(q) : norm_t'(q);
    end
    n.nx = r[0];
    n.ny = r[1];
    n.nz = r[2];
    return n;
  endfunction

  function automatic bit same_normal(normal_t a, normal_t b);
    return a.nx === b.nx && a.ny === b.ny && a.nz === b.nz && a.degen === b.degen;
  endfunction

  // one command transaction: hold start until the core takes it
  task automatic send_triangle(tri_t t);
    start_i <= 1'b1;
    {first_x_i, first_y_i, first_z_i} <= {t.v[0], t.v[1], t.v[2]};
    {second_x_i, second_y_i, second_z_i} <= {t.v[3], t.v[4], t.v[5]};
    {third_x_i, third_y_i, third_z_i} <= {t.v[6], t.v[7], t.v[8]};
    do @(posedge clk_i); while (busy_o);
    pending_normals.insert(pending_normals.size(), face_normal(t));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        normal_t e;
        e = pending_normals.pop_front();
        if (normal_x_o !== e.nx)
          report_mismatch($sformatf("normal_x %0d, expected %0d", normal_x_o, e.nx));
        if (normal_y_o !== e.ny)
          report_mismatch($sformatf("normal_y %0d, expected %0d", normal_y_o, e.ny));
        if (normal_z_o !== e.nz)
          report_mismatch($sformatf("normal_z %0d, expected %0d", normal_z_o, e.nz));
        if (degenerate_o !== e.degen)
          report_mismatch($sformatf("degenerate %0b, expected %0b", degenerate_o, e.degen));
      end
    end
  end

  function automatic tri_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                    int c0, int c1, int c2);
    tri_t t;
    t.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
            coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
    return t;
  endfunction

  function automatic normal_t mk_norm(int x, int y, int z, logic d);
    normal_t n;
    n.nx = norm_t'(x);
    n.ny = norm_t'(y);
    n.nz = norm_t'(z);
    n.degen = d;
    return n;
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int spread;
    case ($urandom_range(0, 9))
      0: begin  // tight cluster around a random point
        spread = $urandom_range(1, 8);
        for (int i = 0; i < 3; i++) t.v[3+i] = coord_t'($urandom_range(0, 65535));
        for (int i = 0; i < 3; i++) begin
          t.v[i] = t.v[3+i] + coord_t'($urandom_range(0, 2 * spread) - spread);
          t.v[6+i] = t.v[3+i] + coord_t'($urandom_range(0, 2 * spread) - spread);
        end
      end
      1: begin  // third vertex takes each coordinate from the first or second vertex
        for (int i = 0; i < 6; i++) t.v[i] = coord_t'($urandom_range(0, 65535));
        for (int i = 0; i < 3; i++)
          t.v[6+i] = $urandom_range(0, 1) ? t.v[i] : t.v[3+i];
      end
      2: begin  // extreme corners only
        for (int i = 0; i < 9; i++) t.v[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        for (int i = 0; i < 9; i++) t.v[i] = coord_t'($urandom_range(0, 65535));
      end
    endcase
    return t;
  endfunction

  row_t table_rows[$];

  function automatic void add_row(tri_t t, logic known, normal_t n);
    row_t r;
    r.t = t;
    r.known = known;
    r.n = n;
    table_rows.insert(table_rows.size(), r);
  endfunction

  initial begin
    add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_norm(0, 0, 0, 1));
    add_row(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                     -32768, -32768, -32768), 1'b1, mk_norm(0, 0, 0, 1));
    add_row(make_tri(256, 0, 0, 0, 0, 0, 0, 256, 0), 1'b1, mk_norm(0, 0, 16384, 0));
    add_row(make_tri(256, 0, 0, 0, 0, 0, 0, -256, 0), 1'b1, mk_norm(0, 0, -16384, 0));
    add_row(make_tri(0, 256, 0, 0, 0, 0, 0, 0, 256), 1'b1, mk_norm(16384, 0, 0, 0));
    add_row(make_tri(0, 0, 256, 0, 0, 0, 256, 0, 0), 1'b1, mk_norm(0, 16384, 0, 0));
    add_row(make_tri(32767, -32768, 0, -32768, -32768, 0, -32768, 32767, 0),
            1'b1, mk_norm(0, 0, 16384, 0));
    add_row(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9), 1'b1, mk_norm(0, 0, 0, 1));
    add_row(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
                     32767, -32768, 32767), 1'b0, mk_norm(0, 0, 0, 0));
    add_row(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                     -32768, -32768, 32767), 1'b0, mk_norm(0, 0, 0, 0));
    add_row(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, mk_norm(0, 0, 0, 0));
    add_row(make_tri(256, 256, 0, 0, 0, 0, 0, 256, 256), 1'b0, mk_norm(0, 0, 0, 0));
    add_row(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 0), 1'b0, mk_norm(0, 0, 0, 0));
    add_row(make_tri(32767, 0, 0, -32768, 0, 0, -32768, 1, 0), 1'b0, mk_norm(0, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].known && !same_normal(face_normal(table_rows[i].t), table_rows[i].n))
        report_mismatch($sformatf("predictor disagrees with table row %0d", i));
      send_triangle(table_rows[i].t);
    end

    for (int i = 0; i < 1050; i++) begin
      if (i == 500) begin
        // drain everything before carrying on
        start_i <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk_i);
      end
      if (i == 900) quiet = 1'b1;
      send_triangle(random_tri());
    end
    start_i <= 1'b0;

    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_fifo.sv
rtl/tun_back.sv
rtl/triangle_unit_normal_core.sv
rtl/tun_checker.sv
dv/triangle_unit_normal_core_tb.sv
